// ===== rtl/arpc_pkg.sv =====
// Shared constants, operation codes and scan status type for the ARP cache table.
// No dependencies; used by arpc_scan_unit and arp_cache_table.
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int MODE_W      = 2;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int STAMP_W     = 8;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    localparam logic [IP_W-1:0] IP_EMPTY = 32'h0000_0000;

    // Outcome flags of one pass over the table
    typedef struct packed {
        logic match;        // a valid entry holds the key
        logic empty_found;  // at least one slot is empty
    } scan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/arpc_scan_unit.sv =====
// Shared compare unit: consumes one table entry per cycle while live is high and tracks
// the first match, the lowest empty slot and the oldest entry. Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpc_scan_unit #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               clear,
    input  wire logic                               live,
    input  wire logic [$clog2(ENTRIES)-1:0]         idx,
    input  wire logic                               entry_valid,
    input  wire logic [arpc_pkg::IP_W-1:0]          entry_ip,
    input  wire logic [arpc_pkg::MAC_W-1:0]         entry_mac,
    input  wire logic [arpc_pkg::STAMP_W-1:0]       entry_stamp,
    input  wire logic [arpc_pkg::IP_W-1:0]          key,
    input  wire logic [arpc_pkg::STAMP_W-1:0]       age_count,
    output arpc_pkg::scan_stat_t                    stat,
    output logic [$clog2(ENTRIES)-1:0]              match_idx,
    output logic [arpc_pkg::MAC_W-1:0]              match_mac,
    output logic [$clog2(ENTRIES)-1:0]              empty_idx,
    output logic [$clog2(ENTRIES)-1:0]              victim_idx
);

    localparam int IDX_W = $clog2(ENTRIES);

    arpc_pkg::scan_stat_t               stat_reg;
    logic                               have_victim_reg;
    logic [arpc_pkg::STAMP_W-1:0]       oldest_reg;
    logic [IDX_W-1:0]                   match_idx_reg;
    logic [IDX_W-1:0]                   empty_idx_reg;
    logic [IDX_W-1:0]                   victim_idx_reg;
    logic [arpc_pkg::MAC_W-1:0]         match_mac_reg;

    logic [arpc_pkg::STAMP_W-1:0]       age;
    logic                               is_match;
    logic                               take_empty;
    logic                               take_victim;

    assign age         = age_count - entry_stamp;
    assign is_match    = live && entry_valid && (entry_ip == key) && !stat_reg.match;
    assign take_empty  = live && !entry_valid && !stat_reg.empty_found;
    assign take_victim = live && entry_valid && (!have_victim_reg || (age > oldest_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg        <= '0;
            have_victim_reg <= 1'b0;
        end
        else if (clear)
        begin
            stat_reg        <= '0;
            have_victim_reg <= 1'b0;
        end
        else
        begin
            if (is_match)
                stat_reg.match <= 1'b1;
            if (take_empty)
                stat_reg.empty_found <= 1'b1;
            if (take_victim)
                have_victim_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_match)
        begin
            match_idx_reg <= idx;
            match_mac_reg <= entry_mac;
        end
        if (take_empty)
            empty_idx_reg <= idx;
        if (take_victim)
        begin
            victim_idx_reg <= idx;
            oldest_reg     <= age;
        end
    end

    assign stat       = stat_reg;
    assign match_idx  = match_idx_reg;
    assign match_mac  = match_mac_reg;
    assign empty_idx  = empty_idx_reg;
    assign victim_idx = victim_idx_reg;

endmodule

`default_nettype wire

// ===== rtl/arp_cache_table.sv =====
// ARP cache table: ENTRIES slots mapping IPv4 addresses to MAC addresses.
// A request is taken only in IDLE, so a new request waits until the last one is done. The
// sequencer scans the table memories one entry per cycle (SCAN) into the shared compare
// unit, feeds in the last read data (LAST), then writes back and loads the result (APPLY).
// Reset clears all valid bits (every slot empty) and the age counter at once.
// Depends on arpc_pkg and arpc_scan_unit.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_table #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [79:0]    s_tdata,   // [31:0] ip_key, [79:32] mac_value
    input  wire logic [1:0]     s_tuser,   // [1:0] mode
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [47:0]         m_tdata,   // [47:0] mac_out
    output logic [0:0]          m_tuser    // [0] hit
);

    localparam int IDX_W = $clog2(ENTRIES);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // wait for a request
    localparam logic [1:0] ST_SCAN  = 2'd1;  // issue one table read per cycle
    localparam logic [1:0] ST_LAST  = 2'd2;  // last read data enters the compare unit
    localparam logic [1:0] ST_APPLY = 2'd3;  // write back, tick, load the result

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;

    // Captured request
    logic [arpc_pkg::MODE_W-1:0]        mode_reg;
    logic [arpc_pkg::IP_W-1:0]          key_reg;
    logic [arpc_pkg::MAC_W-1:0]         mac_in_reg;

    logic [IDX_W-1:0]                   scan_idx_reg;
    logic [arpc_pkg::STAMP_W-1:0]       age_reg;
    logic [ENTRIES-1:0]                 valid_reg;

    // Table memories
    logic [arpc_pkg::IP_W-1:0]          ip_mem    [ENTRIES];
    logic [arpc_pkg::MAC_W-1:0]         mac_mem   [ENTRIES];
    logic [arpc_pkg::STAMP_W-1:0]       stamp_mem [ENTRIES];

    // Registered read port
    logic                               rd_live_reg;
    logic [IDX_W-1:0]                   rd_idx_reg;
    logic                               rd_valid_reg;
    logic [arpc_pkg::IP_W-1:0]          ip_rd_reg;
    logic [arpc_pkg::MAC_W-1:0]         mac_rd_reg;
    logic [arpc_pkg::STAMP_W-1:0]       stamp_rd_reg;

    // Output register
    logic                               m_tvalid_reg;
    logic                               hit_reg;
    logic [arpc_pkg::MAC_W-1:0]         mac_out_reg;

    arpc_pkg::scan_stat_t               stat;
    logic [IDX_W-1:0]                   match_idx;
    logic [arpc_pkg::MAC_W-1:0]         match_mac;
    logic [IDX_W-1:0]                   empty_idx;
    logic [IDX_W-1:0]                   victim_idx;

    logic                               accept;
    logic                               out_free;
    logic                               finish;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_idx;
    logic                               lookup_hit;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // Hold the result in APPLY until the output register is free
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_APPLY) && out_free;

    // Refresh a matching slot, else fill the lowest empty slot, else evict the oldest
    assign wr_idx = stat.match       ? match_idx :
                    stat.empty_found ? empty_idx : victim_idx;
    assign wr_en  = finish && (mode_reg == arpc_pkg::MODE_ADD)
                    && (key_reg != arpc_pkg::IP_EMPTY);

    // Empty slots never match and a zero key is never written, so a zero key can never hit
    assign lookup_hit = (mode_reg == arpc_pkg::MODE_LOOKUP) && stat.match;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (scan_idx_reg == IDX_W'(ENTRIES - 1))
                    state_next = ST_LAST;
            ST_LAST:
                state_next = ST_APPLY;
            ST_APPLY:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            age_reg      <= '0;
            valid_reg    <= '0;
            rd_live_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_live_reg  <= (state_reg == ST_SCAN);
            rd_valid_reg <= valid_reg[scan_idx_reg];
            // Advance the scan address; wrap to zero after the last entry
            if (accept)
                scan_idx_reg <= '0;
            else if (state_reg == ST_SCAN)
                scan_idx_reg <= (scan_idx_reg == IDX_W'(ENTRIES - 1)) ? '0
                                : scan_idx_reg + IDX_W'(1);
            if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
            if (finish && (mode_reg == arpc_pkg::MODE_TICK))
                age_reg <= age_reg + arpc_pkg::STAMP_W'(1);
            if (finish)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers and table memories
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= s_tuser;
            key_reg    <= s_tdata[31:0];
            mac_in_reg <= s_tdata[79:32];
        end
        if (wr_en)
        begin
            ip_mem[wr_idx]    <= key_reg;
            mac_mem[wr_idx]   <= mac_in_reg;
            stamp_mem[wr_idx] <= age_reg;
        end
        rd_idx_reg   <= scan_idx_reg;
        ip_rd_reg    <= ip_mem[scan_idx_reg];
        mac_rd_reg   <= mac_mem[scan_idx_reg];
        stamp_rd_reg <= stamp_mem[scan_idx_reg];
        if (finish)
        begin
            hit_reg     <= lookup_hit;
            mac_out_reg <= lookup_hit ? match_mac : '0;
        end
    end

    arpc_scan_unit #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .live        (rd_live_reg),
        .idx         (rd_idx_reg),
        .entry_valid (rd_valid_reg),
        .entry_ip    (ip_rd_reg),
        .entry_mac   (mac_rd_reg),
        .entry_stamp (stamp_rd_reg),
        .key         (key_reg),
        .age_count   (age_reg),
        .stat        (stat),
        .match_idx   (match_idx),
        .match_mac   (match_mac),
        .empty_idx   (empty_idx),
        .victim_idx  (victim_idx)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = mac_out_reg;
    assign m_tuser[0] = hit_reg;

    // A miss never carries a hardware address
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss result with nonzero mac_out");

    // Slots are never freed
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) >= $past($countones(valid_reg)))
        else $error("valid slot count dropped");

    // An accepted request always starts a scan from entry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("scan did not start after request");

    // A full table never reports an empty slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) && (valid_reg == '1) |-> !stat.empty_found)
        else $error("empty slot reported in a full table");

endmodule

`default_nettype wire
